// File: src/alu816_pkg.sv
// ----------------------------------------------------------------------------
// alu816_pkg
// types and constants shared by the 8/16-bit alu with flags
// ----------------------------------------------------------------------------
package alu816_pkg;

    // operation codes
    typedef enum logic [3:0] {
        FN_ADD     = 4'd0,
        FN_SUB     = 4'd1,
        FN_CMP     = 4'd2,
        FN_AND     = 4'd3,
        FN_OR      = 4'd4,
        FN_XOR     = 4'd5,
        FN_INC     = 4'd6,
        FN_DEC     = 4'd7,
        FN_SHL     = 4'd8,
        FN_ROL     = 4'd9,
        FN_SHR     = 4'd10,
        FN_ROR     = 4'd11,
        FN_TRB     = 4'd12,
        FN_TSB     = 4'd13,
        FN_BIT     = 4'd14,
        FN_BIT_IMM = 4'd15
    } t_func;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned EXT_W  = DATA_W + 1;

    // width masks, sign bits and carry position, one bit above the data
    localparam logic [EXT_W-1:0] MASK_16 = 17'h0FFFF;
    localparam logic [EXT_W-1:0] MASK_8  = 17'h000FF;
    localparam logic [EXT_W-1:0] SIGN_16 = 17'h08000;
    localparam logic [EXT_W-1:0] SIGN_8  = 17'h00080;
    localparam logic [EXT_W-1:0] TOP_16  = 17'h10000;
    localparam logic [EXT_W-1:0] TOP_8   = 17'h00100;

    typedef struct packed {
        t_func             func;
        logic              narrow;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [DATA_W-1:0] accumulator;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              result_valid;
        logic              carry_out;
        logic              overflow_out;
        logic              negative_out;
        logic              zero_out;
    } t_rsp;

    typedef struct packed {
        logic c;
        logic v;
        logic n;
        logic z;
    } t_flags;

endpackage

// File: src/alu816_exec.sv
// ----------------------------------------------------------------------------
// alu816_exec
// one-pass datapath: result and next flags from a request and current flags
// ----------------------------------------------------------------------------
module alu816_exec (
    input  alu816_pkg::t_req   i_req,
    input  alu816_pkg::t_flags i_flags,
    output alu816_pkg::t_rsp   o_rsp,
    output alu816_pkg::t_flags o_flags
);
    import alu816_pkg::*;

    logic [EXT_W-1:0] mask;
    logic [EXT_W-1:0] sign;
    logic [EXT_W-1:0] top;
    logic [EXT_W-1:0] a;
    logic [EXT_W-1:0] b;
    logic [EXT_W-1:0] acc;
    logic [EXT_W-1:0] bb;
    logic [EXT_W-1:0] cin_top;
    logic [EXT_W-1:0] sh_in;
    logic [EXT_W-1:0] r;
    logic [EXT_W-1:0] r_m;
    logic             znc;
    logic             valid;
    logic             test_z;
    t_flags           nf;

    always_comb begin
        mask    = i_req.narrow ? MASK_8 : MASK_16;
        sign    = i_req.narrow ? SIGN_8 : SIGN_16;
        top     = i_req.narrow ? TOP_8  : TOP_16;
        a       = {1'b0, i_req.operand_a} & mask;
        b       = {1'b0, i_req.operand_b} & mask;
        acc     = {1'b0, i_req.accumulator} & mask;
        cin_top = i_flags.c ? top : '0;
        test_z  = ((acc & a) == '0);
        bb      = (i_req.func == FN_ADD) ? b : (b ^ mask);
        sh_in   = a | (((i_req.func == FN_ROR) && i_flags.c) ? top : '0);
        r       = '0;
        znc     = 1'b1;
        valid   = 1'b1;
        nf      = i_flags;

        unique case (i_req.func)
            FN_ADD, FN_SUB: begin
                r    = a + bb + {{(EXT_W-1){1'b0}}, i_flags.c};
                nf.v = |(~(a ^ bb) & (a ^ r) & sign);
            end
            FN_CMP: r = a + bb + {{(EXT_W-1){1'b0}}, 1'b1};
            FN_AND: r = (a & b) | cin_top;
            FN_OR:  r = (a | b) | cin_top;
            FN_XOR: r = (a ^ b) | cin_top;
            FN_INC: r = ((a + {{(EXT_W-1){1'b0}}, 1'b1}) & mask) | cin_top;
            FN_DEC: r = ((a - {{(EXT_W-1){1'b0}}, 1'b1}) & mask) | cin_top;
            FN_SHL: r = a << 1;
            FN_ROL: r = (a << 1) | {{(EXT_W-1){1'b0}}, i_flags.c};
            FN_SHR, FN_ROR: r = (sh_in >> 1) | (a[0] ? top : '0);
            FN_TRB: begin
                r    = ~acc & mask & a;
                nf.z = test_z;
                znc  = 1'b0;
            end
            FN_TSB: begin
                r    = acc | a;
                nf.z = test_z;
                znc  = 1'b0;
            end
            FN_BIT: begin
                nf.n  = |(a & sign);
                nf.v  = |(a & (sign >> 1));
                nf.z  = test_z;
                valid = 1'b0;
                znc   = 1'b0;
            end
            FN_BIT_IMM: begin
                nf.z  = test_z;
                valid = 1'b0;
                znc   = 1'b0;
            end
        endcase

        r_m = r & mask;
        if (znc) begin
            // carry is the bit just above the active width
            nf.c = i_req.narrow ? r[8] : r[DATA_W];
            nf.z = (r_m == '0);
            nf.n = |(r_m & sign);
        end

        o_rsp.result       = valid ? r_m[DATA_W-1:0] : '0;
        o_rsp.result_valid = valid;
        o_rsp.carry_out    = nf.c;
        o_rsp.overflow_out = nf.v;
        o_rsp.negative_out = nf.n;
        o_rsp.zero_out     = nf.z;
        o_flags            = nf;
    end

endmodule

// File: src/cpu_alu_8_16_with_flags.sv
// ----------------------------------------------------------------------------
// cpu_alu_8_16_with_flags
// 8/16-bit alu with carry, overflow, negative and zero flags
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+--------------------
//  request   | in        | i_req_valid / o_req_ready  | i_req (t_req)
//  response  | out       | o_rsp_valid / i_rsp_ready  | o_rsp (t_rsp)
//
//  one item per cycle sustained while i_rsp_ready is high; an item passes
//  the input register, then the result register that drives o_rsp_valid
//  the flag register feeds the datapath and is written as an item moves
//  into the result register, so a following item sees the new flags
//  synchronous active-low reset clears the valid bits and all flags
//  a stalled response holds the result register; the input register
//  still takes one more item, then ready drops until the response drains
// ----------------------------------------------------------------------------
module cpu_alu_8_16_with_flags (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  alu816_pkg::t_req  i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output alu816_pkg::t_rsp  o_rsp
);
    import alu816_pkg::*;

    // input register
    logic   r_in_valid;
    t_req   r_in;
    // result register
    logic   r_out_valid;
    t_rsp   r_out;
    // architectural flags
    t_flags r_flags;

    t_rsp   n_rsp;
    t_flags n_flags;
    logic   advance;
    logic   accept;

    alu816_exec u_exec (
        .i_req   (r_in),
        .i_flags (r_flags),
        .o_rsp   (n_rsp),
        .o_flags (n_flags)
    );

    // input item moves on when the result register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_in_valid || advance;
    assign accept      = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule
